// ----- src/hcbd_pkg.sv -----
package hcbd_pkg;

    localparam int LEN_W      = 32;
    localparam int CFG_W      = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] MODE_CLOSE = 2'd0;
    localparam logic [1:0] MODE_CLEN  = 2'd1;
    localparam logic [1:0] MODE_CHUNK = 2'd2;

    localparam logic [1:0] REG_TRANSFER_MODE   = 2'd0;
    localparam logic [1:0] REG_BODY_LENGTH     = 2'd1;
    localparam logic [1:0] REG_DECODE_TRANSFER = 2'd2;

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_CLOSE     = 3'd1;
    localparam logic [2:0] PH_CLEN      = 3'd2;
    localparam logic [2:0] PH_CH_LEAD   = 3'd3;
    localparam logic [2:0] PH_CH_LEADLF = 3'd4;
    localparam logic [2:0] PH_CH_SIZE   = 3'd5;
    localparam logic [2:0] PH_CH_DATA   = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_AFTER_DONE = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd2;
    localparam logic [1:0] ERR_EARLY_END  = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [1:0]       transfer_mode;
        logic [CFG_W-1:0] body_length;
        logic             decode_transfer;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] body_byte;
        logic [1:0] error_code;
    } t_res;

    typedef struct packed {
        logic a_valid;
        t_res a;
        logic b_valid;
        t_res b;
    } t_step_res;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] val;
    } t_hex;

    function automatic t_res mk_res(logic [1:0] kind, logic [7:0] body_byte,
                                    logic [1:0] error_code);
        t_res r;
        r.kind       = kind;
        r.body_byte  = body_byte;
        r.error_code = error_code;
        return r;
    endfunction

    function automatic t_hex hex_decode(logic [7:0] b);
        t_hex h;
        h.is_hex = 1'b1;
        h.val    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- src/http_chunked_body_decoder_core.sv -----
// HTTP/1.1 body framer. Raw message bytes enter on the s_axis channel, one
// byte per word, tlast set on the byte after which the connection closes.
// Header bytes are dropped up to CR LF CR LF; body bytes are then framed as
// close-delimited, content-length or chunked, per the configuration written
// through i_cfg_we / i_cfg_addr / i_cfg_data (index 0 transfer mode, 1 body
// length, 2 decode enable). The user must write configuration only while idle
// (the block does not enforce it). Each result leaves on m_axis: tuser
// carries the kind (body byte, complete, error), tdata the body byte and the
// error code. Each accepted byte is decoded in the cycle it is taken; its
// results (none, one or two) show on m_axis from the next cycle on. The
// throughput is one byte per cycle as long as each byte yields at most one
// result; the four-entry result queue sets that figure, since s_axis_tready
// stays high only while the queue has room for two results. A stalled
// m_axis fills the queue and then drops s_axis_tready; nothing is
// lost. Reset (synchronous, active low) returns to header scan, empties the
// queue and restores the register defaults (close mode, length zero, decode
// on). After completion or an error every further byte gives an error.
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] body_byte, [9:8] error_code, rest zero
    output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_step_res step_res;
    t_res      head;
    logic      has_room;
    logic      accept;

    assign s_axis_tready = has_room;
    assign accept        = s_axis_tvalid && has_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transfer_mode   <= MODE_CLOSE;
            r_cfg.body_length     <= '0;
            r_cfg.decode_transfer <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TRANSFER_MODE:   r_cfg.transfer_mode   <= i_cfg_data[1:0];
                REG_BODY_LENGTH:     r_cfg.body_length     <= i_cfg_data;
                REG_DECODE_TRANSFER: r_cfg.decode_transfer <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hcbd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (s_axis_tdata),
        .i_eoi   (s_axis_tlast),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    hcbd_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (step_res),
        .i_pop      (m_axis_tready),
        .o_has_room (has_room),
        .o_valid    (m_axis_tvalid),
        .o_head     (head)
    );

    assign m_axis_tdata = {6'd0, head.error_code, head.body_byte};
    assign m_axis_tuser = head.kind;

endmodule

// ----- src/hcbd_step.sv -----
module hcbd_step
    import hcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  t_cfg       i_cfg,
    output t_step_res  o_res
);

    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_crlf, n_crlf;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_ign, n_ign;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cnt_inc;
    logic [LEN_W-1:0] rem_dec;
    logic [1:0]       mode;
    logic [1:0]       sl_crlf_in;
    logic             sl_line_end;
    logic [7:0]       hdr_pat;
    logic             do_size;
    t_hex             hx;
    t_step_res        res;
    t_res             eoi_res;

    assign len         = LEN_W'(i_cfg.body_length);
    assign cnt_inc     = r_count + 1'b1;
    assign rem_dec     = r_rem - 1'b1;
    assign mode        = i_cfg.decode_transfer ? i_cfg.transfer_mode : MODE_CLOSE;
    assign hx          = hex_decode(i_byte);
    assign sl_crlf_in  = (r_phase == PH_CH_SIZE) ? r_crlf : 2'd0;
    assign sl_line_end = (sl_crlf_in == 2'd1) && (i_byte == CH_LF);
    assign hdr_pat     = r_crlf[0] ? CH_LF : CH_CR;

    always_comb begin
        n_phase = r_phase;
        n_crlf  = r_crlf;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_count = r_count;
        n_ign   = r_ign;
        do_size = 1'b0;
        res     = '0;
        eoi_res = '0;
        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_byte == hdr_pat) begin
                        if (r_crlf == 2'd3) begin
                            n_crlf  = 2'd0;
                            n_count = '0;
                            n_rem   = '0;
                            n_acc   = '0;
                            n_ign   = 1'b0;
                            case (mode)
                                MODE_CLEN: begin
                                    n_phase = PH_CLEN;
                                    if (len == '0) begin
                                        res.a_valid = 1'b1;
                                        res.a       = mk_res(KIND_COMPLETE, 8'd0, ERR_NONE);
                                        n_phase     = PH_DONE;
                                    end
                                end
                                MODE_CHUNK: begin
                                    n_phase = PH_CH_LEAD;
                                end
                                default: begin
                                    n_phase = PH_CLOSE;
                                end
                            endcase
                        end else begin
                            n_crlf = r_crlf + 2'd1;
                        end
                    end else begin
                        n_crlf = (i_byte == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_CLOSE: begin
                    res.a_valid = 1'b1;
                    res.a       = mk_res(KIND_BYTE, i_byte, ERR_NONE);
                end
                PH_CLEN: begin
                    res.a_valid = 1'b1;
                    if (r_count >= len) begin
                        res.a   = mk_res(KIND_ERROR, 8'd0, ERR_AFTER_DONE);
                        n_phase = PH_DONE;
                    end else begin
                        res.a   = mk_res(KIND_BYTE, i_byte, ERR_NONE);
                        n_count = cnt_inc;
                        if (cnt_inc == len) begin
                            res.b_valid = 1'b1;
                            res.b       = mk_res(KIND_COMPLETE, 8'd0, ERR_NONE);
                            n_phase     = PH_DONE;
                        end
                    end
                end
                PH_CH_LEAD: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_CH_LEADLF;
                    end else begin
                        n_phase = PH_CH_SIZE;
                        do_size = 1'b1;
                    end
                end
                PH_CH_LEADLF: begin
                    n_phase = PH_CH_SIZE;
                    if (i_byte == CH_LF) begin
                        n_crlf = 2'd0;
                    end else begin
                        n_ign  = 1'b1;
                        n_crlf = (i_byte == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_CH_SIZE: begin
                    do_size = 1'b1;
                end
                PH_CH_DATA: begin
                    res.a_valid = 1'b1;
                    res.a       = mk_res(KIND_BYTE, i_byte, ERR_NONE);
                    n_rem       = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_CH_LEAD;
                        n_crlf  = 2'd0;
                    end
                end
                default: begin
                    res.a_valid = 1'b1;
                    res.a       = mk_res(KIND_ERROR, 8'd0, ERR_AFTER_DONE);
                    n_phase     = PH_DONE;
                end
            endcase

            if (do_size) begin
                if (sl_line_end) begin
                    n_acc  = '0;
                    n_ign  = 1'b0;
                    n_crlf = 2'd0;
                    if (r_acc == '0) begin
                        res.a_valid = 1'b1;
                        res.a       = mk_res(KIND_COMPLETE, 8'd0, ERR_NONE);
                        n_phase     = PH_DONE;
                    end else begin
                        n_rem   = r_acc;
                        n_phase = PH_CH_DATA;
                    end
                end else begin
                    n_crlf = (i_byte == CH_CR) ? 2'd1 : 2'd0;
                    if (!hx.is_hex) begin
                        n_ign = 1'b1;
                    end else if (!r_ign) begin
                        if (r_acc[LEN_W-1 -: 4] != 4'd0) begin
                            res.a_valid = 1'b1;
                            res.a       = mk_res(KIND_ERROR, 8'd0, ERR_OVERFLOW);
                            n_phase     = PH_DONE;
                        end else begin
                            n_acc = {r_acc[LEN_W-5:0], hx.val};
                        end
                    end
                end
            end

            if (i_eoi && r_phase != PH_DONE && n_phase != PH_DONE) begin
                if (n_phase == PH_CLOSE) begin
                    eoi_res = mk_res(KIND_COMPLETE, 8'd0, ERR_NONE);
                end else begin
                    eoi_res = mk_res(KIND_ERROR, 8'd0, ERR_EARLY_END);
                end
                if (res.a_valid) begin
                    res.b_valid = 1'b1;
                    res.b       = eoi_res;
                end else begin
                    res.a_valid = 1'b1;
                    res.a       = eoi_res;
                end
                n_phase = PH_DONE;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_crlf  <= 2'd0;
            r_rem   <= '0;
            r_acc   <= '0;
            r_count <= '0;
            r_ign   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_crlf  <= n_crlf;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_ign   <= n_ign;
        end
    end

`ifndef SYNTHESIS
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.b_valid |-> res.a_valid)
        else $error("second result without first");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |=> r_phase == PH_DONE)
        else $error("left done phase");

    a_after_done_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_phase == PH_DONE) |->
            (res.a_valid && !res.b_valid && res.a.kind == KIND_ERROR
             && res.a.error_code == ERR_AFTER_DONE))
        else $error("byte after done not flagged");
`endif

endmodule

// ----- src/hcbd_res_fifo.sv -----
module hcbd_res_fifo
    import hcbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_res i_wr,
    input  logic      i_pop,
    output logic      o_has_room,
    output logic      o_valid,
    output t_res      o_head
);

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    logic [1:0]         wr_n;
    logic               pop;
    t_res               first;

    assign wr_n       = 2'(i_wr.a_valid) + 2'(i_wr.b_valid);
    assign first      = i_wr.a_valid ? i_wr.a : i_wr.b;
    assign o_valid    = (r_count != '0);
    assign pop        = i_pop && o_valid;
    assign o_has_room = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_n != 2'd0) begin
            r_mem[r_wr_ptr] <= first;
        end
        if (wr_n == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_wr.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(wr_n);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= r_count + FIFO_CW'(wr_n) - FIFO_CW'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_n != 2'd0) |-> o_has_room)
        else $error("result queue written without room");
`endif

endmodule
